// ----- sv/alqr_pkg.sv -----
// Shared constants and helpers for the angle LQR feedback block.
// Has no dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none
package alqr_pkg;
    localparam int GAIN_W = 24;
    localparam int LIM_W = 31;
    localparam int DB_W = 15;
    localparam int DECAY_W = 16;
    localparam int ANG_W = 16;
    localparam int RATE_W = 20;
    localparam int DT_W = 20;
    localparam int OUT_W = 32;
    localparam int ERR_W = 17;
    localparam int CFG_W = 31;
    localparam int DECAY_THRESHOLD_DEF = 1229;
    localparam logic signed [ERR_W-1:0] PI_Q12 = 17'sd12868;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 17'sd25736;

    localparam logic [2:0] REG_ANGLE_GAIN = 3'd0;
    localparam logic [2:0] REG_RATE_GAIN = 3'd1;
    localparam logic [2:0] REG_INT_GAIN = 3'd2;
    localparam logic [2:0] REG_OUT_LIMIT = 3'd3;
    localparam logic [2:0] REG_INT_ENABLE = 3'd4;
    localparam logic [2:0] REG_INT_BOUND = 3'd5;
    localparam logic [2:0] REG_DEADBAND = 3'd6;
    localparam logic [2:0] REG_DECAY = 3'd7;

    typedef struct packed {
        logic start;
        logic is_signed;
    } mul_ctl_t;
endpackage
`default_nettype wire

// ----- sv/alqr_sermul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on alqr_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none
module alqr_sermul
    import alqr_pkg::*;
#(
    parameter int AW = 48,
    parameter int BW = 32
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  mul_ctl_t                 ctl,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    output logic                     done,
    output logic signed [AW+BW-1:0]  p
);
    localparam int CW = $clog2(BW + 1);
    logic signed [AW+BW-1:0] acc_reg, acc_next, mcand_reg, mcand_next;
    logic [BW-1:0] mplier_reg, mplier_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic sgn_reg, sgn_next;

    always_comb
    begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        sgn_next = sgn_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            acc_next = '0;
            if (ctl.is_signed)
                mcand_next = (AW+BW)'(a);
            else
                mcand_next = (AW+BW)'($unsigned(a));
            mplier_next = b;
            cnt_next = '0;
            busy_next = 1'b1;
            sgn_next = ctl.is_signed;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                if (cnt_reg == CW'(BW - 1) && sgn_reg)
                    acc_next = acc_reg - mcand_reg;
                else
                    acc_next = acc_reg + mcand_reg;
            end
            mcand_next = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(BW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        sgn_reg <= sgn_next;
    end

    assign done = done_reg;
    assign p = acc_reg;
endmodule
`default_nettype wire

// ----- sv/angle_lqr_feedback_with_integral.sv -----
// Top level of the angle LQR feedback block with integral action.
// Depends on alqr_pkg and alqr_sermul.
`timescale 1ns / 1ps
`default_nettype none
// A control item keeps the block busy from when it is taken until its result is registered:
// the error is wrapped into range, then up to five products pass in turn through one
// bit-serial multiplier (angle, rate, then error times dt and integral gain when the integral
// is updated, then decay), followed by the integral clamp, the integral sum and the output
// clamp. A clear item does not make the block busy. One item is worked on at a time; the
// result waits in an output register and the next item is taken while it waits, but a
// finished item holds the block until the previous result has been taken.
module angle_lqr_feedback_with_integral
    import alqr_pkg::*;
#(
    parameter int DECAY_THRESHOLD = DECAY_THRESHOLD_DEF
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire                       mode,
    input  wire logic signed [ANG_W-1:0]  target_angle,
    input  wire logic signed [ANG_W-1:0]  measured_angle,
    input  wire logic signed [RATE_W-1:0] measured_rate,
    input  wire logic [DT_W-1:0]      elapsed_time,
    output logic                      out_valid,
    input  wire                       out_stall,
    output logic signed [OUT_W-1:0]   drive_out
);
    localparam int MA = 48;
    localparam int MB = 32;
    localparam int PW = MA + MB;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WRAP = 4'd1;
    localparam logic [3:0] S_M_ANG = 4'd2;
    localparam logic [3:0] S_M_RATE = 4'd3;
    localparam logic [3:0] S_M_EDT = 4'd4;
    localparam logic [3:0] S_M_IG = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_M_DEC = 4'd7;
    localparam logic [3:0] S_ACC = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;
    localparam logic [3:0] S_HOLD = 4'd10;

    logic signed [GAIN_W-1:0] ang_gain_reg, rate_gain_reg, int_gain_reg;
    logic [LIM_W-1:0] out_lim_reg, int_bound_reg;
    logic int_en_reg;
    logic [DB_W-1:0] deadband_reg;
    logic [DECAY_W-1:0] decay_reg;

    logic [3:0] state_reg, state_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [RATE_W-1:0] rate_reg, rate_next;
    logic [DT_W-1:0] dt_reg, dt_next;
    logic signed [PW-1:0] fb_reg, fb_next, inc_reg, inc_next;
    logic signed [OUT_W-1:0] isum_reg, isum_next;
    logic signed [OUT_W-1:0] drive_reg, drive_next;
    logic ovalid_reg, ovalid_next;
    logic mstart_reg, mstart_next;
    logic signed [MA-1:0] ma_reg, ma_next;
    logic signed [MB-1:0] mb_reg, mb_next;
    mul_ctl_t mctl;
    logic mdone;
    logic signed [PW-1:0] mp;

    alqr_sermul #(.AW(MA), .BW(MB)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctl(mctl), .a(ma_reg), .b(mb_reg),
        .done(mdone), .p(mp)
    );
    assign mctl.start = mstart_reg;
    assign mctl.is_signed = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_gain_reg <= '0;
            rate_gain_reg <= '0;
            int_gain_reg <= '0;
            out_lim_reg <= '0;
            int_en_reg <= 1'b0;
            int_bound_reg <= '0;
            deadband_reg <= '0;
            decay_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_GAIN: ang_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_RATE_GAIN:  rate_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_INT_GAIN:   int_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_OUT_LIMIT:  out_lim_reg <= cfg_data[LIM_W-1:0];
                REG_INT_ENABLE: int_en_reg <= cfg_data[0];
                REG_INT_BOUND:  int_bound_reg <= cfg_data[LIM_W-1:0];
                REG_DEADBAND:   deadband_reg <= cfg_data[DB_W-1:0];
                REG_DECAY:      decay_reg <= cfg_data[DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    logic in_acc, out_acc;
    logic [ERR_W-1:0] aerr;
    logic signed [PW-1:0] rnd32, rnd16;
    logic signed [PW-1:0] isum_w, sum_w, lim_w, tot_w;
    logic same_sign;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign out_acc = ovalid_reg && !out_stall;
    assign aerr = err_reg[ERR_W-1] ? 17'(-err_reg) : 17'(err_reg);
    assign same_sign = (err_reg > 0 && isum_reg > 0) || (err_reg < 0 && isum_reg < 0);

    always_comb
    begin
        state_next = state_reg;
        err_next = err_reg;
        rate_next = rate_reg;
        dt_next = dt_reg;
        fb_next = fb_reg;
        inc_next = inc_reg;
        isum_next = isum_reg;
        drive_next = drive_reg;
        ovalid_next = ovalid_reg && !out_acc;
        mstart_next = 1'b0;
        ma_next = ma_reg;
        mb_next = mb_reg;
        rnd32 = (mp + PW'(64'sh80000000)) >>> 32;
        rnd16 = (mp + PW'(64'sd32768)) >>> 16;
        isum_w = '0;
        sum_w = '0;
        lim_w = '0;
        tot_w = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (mode)
                        isum_next = '0;
                    else
                    begin
                        err_next = 17'(target_angle) - 17'(measured_angle);
                        rate_next = measured_rate;
                        dt_next = elapsed_time;
                        state_next = S_WRAP;
                    end
                end
            end
            S_WRAP:
            begin
                if (err_reg > PI_Q12)
                    err_next = err_reg - TWO_PI_Q12;
                else if (err_reg < -PI_Q12)
                    err_next = err_reg + TWO_PI_Q12;
                else
                begin
                    ma_next = MA'(ang_gain_reg);
                    mb_next = MB'(err_reg);
                    mstart_next = 1'b1;
                    state_next = S_M_ANG;
                end
            end
            S_M_ANG:
            begin
                if (mdone)
                begin
                    fb_next = mp;
                    ma_next = MA'(rate_gain_reg);
                    mb_next = MB'(rate_reg);
                    mstart_next = 1'b1;
                    state_next = S_M_RATE;
                end
            end
            S_M_RATE:
            begin
                if (mdone)
                begin
                    fb_next = (fb_reg - mp + PW'(64'sd2048)) >>> 12;
                    if (int_en_reg && dt_reg != '0 && aerr > 17'(deadband_reg))
                    begin
                        ma_next = MA'(err_reg);
                        mb_next = MB'({1'b0, dt_reg});
                        mstart_next = 1'b1;
                        state_next = S_M_EDT;
                    end
                    else
                        state_next = S_ACC;
                end
            end
            S_M_EDT:
            begin
                if (mdone)
                begin
                    ma_next = mp[MA-1:0];
                    mb_next = MB'(int_gain_reg);
                    mstart_next = 1'b1;
                    state_next = S_M_IG;
                end
            end
            S_M_IG:
            begin
                if (mdone)
                begin
                    inc_next = rnd32;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (decay_reg != '0 && same_sign && aerr > 17'(DECAY_THRESHOLD))
                begin
                    ma_next = inc_reg[MA-1:0];
                    mb_next = MB'({1'b0, 17'h10000 - 17'(decay_reg)});
                    mstart_next = 1'b1;
                    state_next = S_M_DEC;
                end
                else
                    state_next = S_ACC;
                isum_w = PW'(isum_reg) + inc_reg;
                lim_w = PW'({1'b0, int_bound_reg});
                if (state_next == S_ACC)
                begin
                    if (isum_w > lim_w)
                        isum_next = OUT_W'(lim_w);
                    else if (isum_w < -lim_w)
                        isum_next = OUT_W'(-lim_w);
                    else
                        isum_next = OUT_W'(isum_w);
                end
            end
            S_M_DEC:
            begin
                if (mdone)
                begin
                    isum_w = PW'(isum_reg) + rnd16;
                    lim_w = PW'({1'b0, int_bound_reg});
                    if (isum_w > lim_w)
                        isum_next = OUT_W'(lim_w);
                    else if (isum_w < -lim_w)
                        isum_next = OUT_W'(-lim_w);
                    else
                        isum_next = OUT_W'(isum_w);
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (int_en_reg && dt_reg != '0)
                    fb_next = fb_reg + PW'(isum_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                sum_w = fb_reg;
                lim_w = PW'({1'b0, out_lim_reg});
                if (sum_w > lim_w)
                    tot_w = lim_w;
                else if (sum_w < -lim_w)
                    tot_w = -lim_w;
                else
                    tot_w = sum_w;
                if (!ovalid_reg || out_acc)
                begin
                    drive_next = OUT_W'(tot_w);
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            mstart_reg <= 1'b0;
            isum_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            mstart_reg <= mstart_next;
            isum_reg <= isum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        rate_reg <= rate_next;
        dt_reg <= dt_next;
        fb_reg <= fb_next;
        inc_reg <= inc_next;
        drive_reg <= drive_next;
        ma_reg <= ma_next;
        mb_reg <= mb_next;
    end

    assign out_valid = ovalid_reg;
    assign drive_out = drive_reg;
endmodule
`default_nettype wire

// ----- sv/alqr_checker.sv -----
// Port-level checks for the angle LQR feedback block, bound to the top level.
// Depends on alqr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module alqr_checker
    import alqr_pkg::*;
(
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_stall,
    input wire                         mode,
    input wire                         out_valid,
    input wire                         out_stall,
    input wire logic signed [OUT_W-1:0] drive_out
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_out))
        else $error("stalled result changed");
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode && !out_valid |=> !out_valid)
        else $error("clear item gave a result");
    a_busy_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode |=> in_stall)
        else $error("step item not held busy");
    a_no_neg_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive_out != 32'sh80000000)
        else $error("result outside symmetric range");
endmodule

bind angle_lqr_feedback_with_integral alqr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .out_valid(out_valid), .out_stall(out_stall), .drive_out(drive_out)
);
`default_nettype wire
